### hdl/ternary_matrix_vector_multiply_macros.svh
// Assertion helpers for the checker file.
`ifndef TERNARY_MATRIX_VECTOR_MULTIPLY_MACROS_SVH
`define TERNARY_MATRIX_VECTOR_MULTIPLY_MACROS_SVH

// Same-cycle implication.
`define TMVM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication.
`define TMVM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### hdl/tmvm_pkg.sv
package tmvm_pkg;

   localparam int MAX_INPUTS       = 256;
   localparam int MAX_OUTPUTS      = 64;
   localparam int WEIGHTS_PER_BYTE = 4;
   localparam int WSTORE_BYTES     = (MAX_INPUTS * MAX_OUTPUTS) / WEIGHTS_PER_BYTE;

   localparam int COL_W   = $clog2(MAX_INPUTS);
   localparam int LEN_W   = COL_W + 1;
   localparam int ROW_W   = $clog2(MAX_OUTPUTS);
   localparam int ROWS_W  = 7;
   localparam int FLAT_W  = 14;
   localparam int LANE_W  = $clog2(WEIGHTS_PER_BYTE);
   localparam int WADDR_W = $clog2(WSTORE_BYTES);
   localparam int ACT_W   = 16;
   localparam int SCALE_W = 16;
   localparam int ACC_W   = ACT_W + COL_W + 1;
   localparam int PROD_W  = ACC_W + SCALE_W;
   localparam int FRAC_W  = 12;
   localparam int RES_W   = 28;
   localparam int CODE_W  = 2;
   localparam int CSR_W   = 32;
   localparam int ADDR_W  = 4;

   localparam logic [LEN_W-1:0]  INPUT_LENGTH_RESET  = LEN_W'(MAX_INPUTS);
   localparam logic [ROWS_W-1:0] OUTPUT_LENGTH_RESET = ROWS_W'(MAX_OUTPUTS);
   localparam logic [SCALE_W-1:0] SCALE_RESET        = SCALE_W'(4096);

   localparam logic [CODE_W-1:0] CODE_ZERO  = 2'b00;
   localparam logic [CODE_W-1:0] CODE_PLUS  = 2'b01;
   localparam logic [CODE_W-1:0] CODE_MINUS = 2'b10;

   typedef enum logic [1:0] {
      CSR_INPUT_LENGTH  = 2'd0,
      CSR_OUTPUT_LENGTH = 2'd1,
      CSR_SCALE_FACTOR  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic             valid;
      logic [ROW_W-1:0] row;
      logic             final_row;
   } row_tag_type;

endpackage

### hdl/tmvm_row_scale.sv
module tmvm_row_scale (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tmvm_pkg::row_tag_type                 sum_tag,
   input  logic signed [tmvm_pkg::ACC_W-1:0]     sum,
   input  logic signed [tmvm_pkg::SCALE_W-1:0]   scale,
   output logic                                  rsp_strobe,
   output logic [tmvm_pkg::ROW_W-1:0]            rsp_row_number,
   output logic signed [tmvm_pkg::RES_W-1:0]     rsp_row_result,
   output logic                                  rsp_final_row
);

   logic signed [tmvm_pkg::PROD_W-1:0] prod_in;
   logic signed [tmvm_pkg::PROD_W-1:0] prod_ff;
   logic signed [tmvm_pkg::PROD_W-1:0] shifted_in;
   tmvm_pkg::row_tag_type              tag_ff;
   logic                               strobe_ff;
   logic [tmvm_pkg::ROW_W-1:0]         row_ff;
   logic signed [tmvm_pkg::RES_W-1:0]  result_ff;
   logic                               final_ff;

   assign prod_in    = sum * scale;
   assign shifted_in = prod_ff >>> tmvm_pkg::FRAC_W;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.valid <= 1'b0;
         strobe_ff    <= 1'b0;
      end else begin
         tag_ff.valid <= sum_tag.valid;
         strobe_ff    <= tag_ff.valid;
      end
      tag_ff.row       <= sum_tag.row;
      tag_ff.final_row <= sum_tag.final_row;
      prod_ff          <= prod_in;
      row_ff           <= tag_ff.row;
      final_ff         <= tag_ff.final_row;
      result_ff        <= shifted_in[tmvm_pkg::RES_W-1:0];
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_row_number = row_ff;
   assign rsp_row_result = result_ff;
   assign rsp_final_row  = final_ff;

endmodule

### hdl/ternary_matrix_vector_multiply.sv
// Ternary matrix-vector multiply. An activation beat with start_compute set starts a run:
// busy stays high until the final row result has been strobed out. Here cols is
// input_length capped at 256 and rows is output_length capped at 64, and with cols zero
// every row returns zero. One weight code is read a cycle from the single read port of
// the weight memory. Each row result appears on the rsp_ ports for exactly one cycle with
// rsp_strobe high; the receiver cannot stall, so it must take every beat as it comes. A
// run with zero rows returns nothing and leaves busy low.
module ternary_matrix_vector_multiply (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_kind,
   input  logic [tmvm_pkg::FLAT_W-1:0]          req_weight_index,
   input  logic signed [tmvm_pkg::CODE_W-1:0]   req_weight_value,
   input  logic [tmvm_pkg::COL_W-1:0]           req_act_index,
   input  logic signed [tmvm_pkg::ACT_W-1:0]    req_act_value,
   input  logic                                 req_start_compute,
   output logic                                 rsp_strobe,
   output logic [tmvm_pkg::ROW_W-1:0]           rsp_row_number,
   output logic signed [tmvm_pkg::RES_W-1:0]    rsp_row_result,
   output logic                                 rsp_final_row,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [tmvm_pkg::ADDR_W-1:0]          paddr,
   input  logic [tmvm_pkg::CSR_W-1:0]           pwdata,
   output logic [tmvm_pkg::CSR_W-1:0]           prdata,
   output logic                                 pready
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   state_type                            state_ff;
   logic [tmvm_pkg::LEN_W-1:0]           input_length_ff;
   logic [tmvm_pkg::ROWS_W-1:0]          output_length_ff;
   logic signed [tmvm_pkg::SCALE_W-1:0]  scale_factor_ff;

   logic [7:0]                           wmem [tmvm_pkg::WSTORE_BYTES];
   logic [tmvm_pkg::ACT_W-1:0]           amem [tmvm_pkg::MAX_INPUTS];
   logic [7:0]                           wq_ff;
   logic signed [tmvm_pkg::ACT_W-1:0]    aq_ff;

   logic [tmvm_pkg::ROW_W-1:0]           row_ff;
   logic [tmvm_pkg::COL_W-1:0]           col_ff;
   logic [tmvm_pkg::FLAT_W-1:0]          flat_ff;

   logic                                 s1_valid_ff;
   logic                                 s1_first_ff;
   logic                                 s1_empty_ff;
   logic                                 s1_last_ff;
   logic                                 s1_final_ff;
   logic [tmvm_pkg::ROW_W-1:0]           s1_row_ff;
   logic [tmvm_pkg::LANE_W-1:0]          s1_lane_ff;
   logic signed [tmvm_pkg::ACC_W-1:0]    acc_ff;
   logic signed [tmvm_pkg::ACC_W-1:0]    acc_in;

   logic [tmvm_pkg::LEN_W-1:0]           cols;
   logic [tmvm_pkg::ROWS_W-1:0]          rows;
   logic                                 item_accept;
   logic                                 run_start;
   logic                                 row_end;
   logic                                 run_end;
   logic                                 csr_write;
   logic [tmvm_pkg::CODE_W-1:0]          wr_code;
   logic [tmvm_pkg::CODE_W-1:0]          rd_code;
   logic signed [tmvm_pkg::ACC_W-1:0]    act_ext;
   logic signed [tmvm_pkg::ACC_W-1:0]    acc_base;
   logic signed [tmvm_pkg::ACC_W-1:0]    acc_term;
   tmvm_pkg::row_tag_type                sum_tag;

   assign cols = (input_length_ff > tmvm_pkg::INPUT_LENGTH_RESET) ?
                 tmvm_pkg::INPUT_LENGTH_RESET : input_length_ff;
   assign rows = (output_length_ff > tmvm_pkg::OUTPUT_LENGTH_RESET) ?
                 tmvm_pkg::OUTPUT_LENGTH_RESET : output_length_ff;

   assign busy        = (state_ff != ST_IDLE);
   assign item_accept = start && !busy;
   assign run_start   = item_accept && req_kind && req_start_compute;
   assign row_end     = (cols == '0) || ({1'b0, col_ff} == cols - tmvm_pkg::LEN_W'(1));
   assign run_end     = row_end && ({1'b0, row_ff} == rows - tmvm_pkg::ROWS_W'(1));

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         input_length_ff  <= tmvm_pkg::INPUT_LENGTH_RESET;
         output_length_ff <= tmvm_pkg::OUTPUT_LENGTH_RESET;
         scale_factor_ff  <= tmvm_pkg::SCALE_RESET;
      end else if (csr_write) begin
         case (tmvm_pkg::csr_index_type'(paddr[3:2]))
            tmvm_pkg::CSR_INPUT_LENGTH: begin
               input_length_ff <= pwdata[tmvm_pkg::LEN_W-1:0];
            end
            tmvm_pkg::CSR_OUTPUT_LENGTH: begin
               output_length_ff <= pwdata[tmvm_pkg::ROWS_W-1:0];
            end
            tmvm_pkg::CSR_SCALE_FACTOR: begin
               scale_factor_ff <= pwdata[tmvm_pkg::SCALE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (tmvm_pkg::csr_index_type'(paddr[3:2]))
         tmvm_pkg::CSR_INPUT_LENGTH:  prdata = tmvm_pkg::CSR_W'(input_length_ff);
         tmvm_pkg::CSR_OUTPUT_LENGTH: prdata = tmvm_pkg::CSR_W'(output_length_ff);
         tmvm_pkg::CSR_SCALE_FACTOR:  prdata = tmvm_pkg::CSR_W'(unsigned'(scale_factor_ff));
         default:                     prdata = '0;
      endcase
   end

   // stores
   assign wr_code = (req_weight_value == 2'sd0) ? tmvm_pkg::CODE_ZERO :
                    (req_weight_value == 2'sd1) ? tmvm_pkg::CODE_PLUS : tmvm_pkg::CODE_MINUS;

   always_ff @(posedge clock) begin
      if (item_accept && !req_kind) begin
         wmem[req_weight_index[tmvm_pkg::FLAT_W-1:tmvm_pkg::LANE_W]]
             [{req_weight_index[tmvm_pkg::LANE_W-1:0], 1'b0} +: tmvm_pkg::CODE_W] <= wr_code;
      end
      if (item_accept && req_kind) begin
         amem[req_act_index] <= req_act_value;
      end
      wq_ff <= wmem[flat_ff[tmvm_pkg::FLAT_W-1:tmvm_pkg::LANE_W]];
      aq_ff <= amem[col_ff];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (run_start) begin
                  state_ff <= (rows == '0) ? ST_IDLE : ST_RUN;
                  row_ff   <= '0;
                  col_ff   <= '0;
                  flat_ff  <= '0;
               end
            end
            ST_RUN: begin
               s1_valid_ff <= 1'b1;
               s1_first_ff <= (col_ff == '0);
               s1_empty_ff <= (cols == '0);
               s1_last_ff  <= row_end;
               s1_final_ff <= run_end;
               s1_row_ff   <= row_ff;
               s1_lane_ff  <= flat_ff[tmvm_pkg::LANE_W-1:0];
               if (row_end) begin
                  col_ff <= '0;
                  row_ff <= row_ff + tmvm_pkg::ROW_W'(1);
                  if (run_end) begin
                     state_ff <= ST_DRAIN;
                  end
               end else begin
                  col_ff <= col_ff + tmvm_pkg::COL_W'(1);
               end
               if (cols != '0) begin
                  flat_ff <= flat_ff + tmvm_pkg::FLAT_W'(1);
               end
            end
            ST_DRAIN: begin
               if (rsp_strobe && rsp_final_row) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // accumulate
   assign rd_code  = wq_ff[{s1_lane_ff, 1'b0} +: tmvm_pkg::CODE_W];
   assign act_ext  = tmvm_pkg::ACC_W'(aq_ff);
   assign acc_base = (s1_first_ff || s1_empty_ff) ? '0 : acc_ff;

   always_comb begin
      case (rd_code)
         tmvm_pkg::CODE_PLUS:  acc_term = act_ext;
         tmvm_pkg::CODE_MINUS: acc_term = -act_ext;
         default:              acc_term = '0;
      endcase
      if (s1_empty_ff) begin
         acc_term = '0;
      end
   end

   assign acc_in = acc_base + acc_term;

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign sum_tag.valid     = s1_valid_ff && s1_last_ff;
   assign sum_tag.row       = s1_row_ff;
   assign sum_tag.final_row = s1_final_ff;

   tmvm_row_scale u_row_scale (
      .clock          (clock),
      .reset          (reset),
      .sum_tag        (sum_tag),
      .sum            (acc_in),
      .scale          (scale_factor_ff),
      .rsp_strobe     (rsp_strobe),
      .rsp_row_number (rsp_row_number),
      .rsp_row_result (rsp_row_result),
      .rsp_final_row  (rsp_final_row)
   );

endmodule

### hdl/tmvm_checker.sv
`include "ternary_matrix_vector_multiply_macros.svh"

module tmvm_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_kind,
   input logic req_start_compute,
   input logic rsp_strobe,
   input logic rsp_final_row
);

   `TMVM_ASSERT_IMPL(a_beat_while_busy, clock, reset, rsp_strobe, busy)
   `TMVM_ASSERT_NEXT(a_final_frees, clock, reset, rsp_strobe && rsp_final_row, !busy)
   `TMVM_ASSERT_NEXT(a_midrun_holds, clock, reset, rsp_strobe && !rsp_final_row, busy)
   `TMVM_ASSERT_NEXT(a_store_only, clock, reset, start && !busy && (!req_kind || !req_start_compute), !busy)

endmodule

bind ternary_matrix_vector_multiply tmvm_checker u_tmvm_checker (.*);

### sim/tb_ternary_matrix_vector_multiply.sv
`timescale 1ns / 1ps

module tb_ternary_matrix_vector_multiply;
   import tmvm_pkg::*;

   localparam logic KIND_WEIGHT = 1'b0;
   localparam logic KIND_ACT    = 1'b1;

   localparam logic [CODE_W-1:0] W_ZERO   = 2'b00;
   localparam logic [CODE_W-1:0] W_PLUS   = 2'b01;
   localparam logic [CODE_W-1:0] W_MINUS2 = 2'b10;
   localparam logic [CODE_W-1:0] W_MINUS  = 2'b11;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 8;

   typedef struct packed {
      logic                     kind;
      logic [FLAT_W-1:0]        windex;
      logic signed [CODE_W-1:0] wvalue;
      logic [COL_W-1:0]         aindex;
      logic signed [ACT_W-1:0]  avalue;
      logic                     go;
   } matvec_op_type;

   typedef struct packed {
      logic [ROW_W-1:0]        row;
      logic signed [RES_W-1:0] result;
      logic                    last;
   } row_result_type;

   class matvec_tracker;
      logic [7:0]                weight_bytes [WSTORE_BYTES];
      logic signed [ACT_W-1:0]   acts [MAX_INPUTS];
      logic [LEN_W-1:0]          in_len;
      logic [ROWS_W-1:0]         out_len;
      logic signed [SCALE_W-1:0] scale;
      row_result_type            pending_rows [$];
      int                        errors;

      function new();
         in_len  = INPUT_LENGTH_RESET;
         out_len = OUTPUT_LENGTH_RESET;
         scale   = SCALE_RESET;
         errors  = 0;
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      function void set_register(csr_index_type idx, logic [CSR_W-1:0] data);
         case (idx)
            CSR_INPUT_LENGTH:  in_len  = data[LEN_W-1:0];
            CSR_OUTPUT_LENGTH: out_len = data[ROWS_W-1:0];
            CSR_SCALE_FACTOR:  scale   = data[SCALE_W-1:0];
            default: ;
         endcase
      endfunction

      task check_register(csr_index_type idx, logic [CSR_W-1:0] got);
         case (idx)
            CSR_INPUT_LENGTH:
               if (got[LEN_W-1:0] !== in_len)
                  report($sformatf("input_length reads %0d, wrote %0d", got[LEN_W-1:0], in_len));
            CSR_OUTPUT_LENGTH:
               if (got[ROWS_W-1:0] !== out_len)
                  report($sformatf("output_length reads %0d, wrote %0d",
                                   got[ROWS_W-1:0], out_len));
            CSR_SCALE_FACTOR:
               if (got[SCALE_W-1:0] !== scale)
                  report($sformatf("scale_factor reads %0h, wrote %0h",
                                   got[SCALE_W-1:0], scale));
            default: ;
         endcase
      endtask

      function void run_product();
         int                        cols;
         int                        rows;
         int                        flat;
         logic [CODE_W-1:0]         code;
         logic signed [ACC_W-1:0]   acc;
         logic signed [PROD_W-1:0]  prod;
         row_result_type            r;
         cols = (in_len > MAX_INPUTS) ? MAX_INPUTS : int'(in_len);
         rows = (out_len > MAX_OUTPUTS) ? MAX_OUTPUTS : int'(out_len);
         for (int i = 0; i < rows; i++) begin
            acc = '0;
            for (int j = 0; j < cols; j++) begin
               flat = i * cols + j;
               code = weight_bytes[flat / WEIGHTS_PER_BYTE]
                                  [(flat % WEIGHTS_PER_BYTE) * CODE_W +: CODE_W];
               if (code == CODE_PLUS)
                  acc = acc + acts[j];
               else if (code == CODE_MINUS)
                  acc = acc - acts[j];
            end
            prod     = acc * scale;
            r.row    = ROW_W'(i);
            r.result = RES_W'(prod >>> FRAC_W);
            r.last   = (i == rows - 1);
            pending_rows.push_back(r);
         end
      endfunction

      function void take_beat(matvec_op_type op);
         logic [CODE_W-1:0] code;
         if (op.kind == KIND_WEIGHT) begin
            case (op.wvalue)
               W_ZERO:  code = CODE_ZERO;
               W_PLUS:  code = CODE_PLUS;
               default: code = CODE_MINUS;
            endcase
            weight_bytes[op.windex[FLAT_W-1:LANE_W]][op.windex[LANE_W-1:0] * CODE_W +: CODE_W]
               = code;
         end else begin
            acts[op.aindex] = op.avalue;
            if (op.go)
               run_product();
         end
      endfunction

      task check_row(logic [ROW_W-1:0] row, logic signed [RES_W-1:0] result, logic last);
         row_result_type e;
         if (pending_rows.size() == 0) begin
            report($sformatf("unexpected row %0d result %0d", row, result));
            return;
         end
         e = pending_rows.pop_front();
         if (row !== e.row)
            report($sformatf("row_number %0d, want %0d", row, e.row));
         if (result !== e.result)
            report($sformatf("row %0d result %0d, want %0d", e.row, result, e.result));
         if (last !== e.last)
            report($sformatf("row %0d final_row %0b, want %0b", e.row, last, e.last));
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic                     req_kind;
   logic [FLAT_W-1:0]        req_weight_index;
   logic signed [CODE_W-1:0] req_weight_value;
   logic [COL_W-1:0]         req_act_index;
   logic signed [ACT_W-1:0]  req_act_value;
   logic                     req_start_compute;
   logic                     rsp_strobe;
   logic [ROW_W-1:0]         rsp_row_number;
   logic signed [RES_W-1:0]  rsp_row_result;
   logic                     rsp_final_row;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [ADDR_W-1:0]        paddr;
   logic [CSR_W-1:0]         pwdata;
   logic [CSR_W-1:0]         prdata;
   logic                     pready;

   matvec_tracker model;
   int            gap_pct;
   int            quiet_cycles;

   ternary_matrix_vector_multiply dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_weight_index  (req_weight_index),
      .req_weight_value  (req_weight_value),
      .req_act_index     (req_act_index),
      .req_act_value     (req_act_value),
      .req_start_compute (req_start_compute),
      .rsp_strobe        (rsp_strobe),
      .rsp_row_number    (rsp_row_number),
      .rsp_row_result    (rsp_row_result),
      .rsp_final_row     (rsp_final_row),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_strobe)
            model.check_row(rsp_row_number, rsp_row_result, rsp_final_row);
         if (start && !busy)
            model.take_beat(matvec_op_type'{req_kind, req_weight_index, req_weight_value,
                                            req_act_index, req_act_value, req_start_compute});
         if ((start && !busy) || rsp_strobe || psel) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL ternary_matrix_vector_multiply");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   function automatic matvec_op_type weight_op(int idx, logic [CODE_W-1:0] val, logic go);
      matvec_op_type op;
      op.kind   = KIND_WEIGHT;
      op.windex = FLAT_W'(idx);
      op.wvalue = val;
      op.aindex = COL_W'($urandom);
      op.avalue = ACT_W'($urandom);
      op.go     = go;
      return op;
   endfunction

   function automatic matvec_op_type act_op(int idx, logic [ACT_W-1:0] val, logic go);
      matvec_op_type op;
      op.kind   = KIND_ACT;
      op.windex = FLAT_W'($urandom);
      op.wvalue = CODE_W'($urandom);
      op.aindex = COL_W'(idx);
      op.avalue = val;
      op.go     = go;
      return op;
   endfunction

   function automatic logic [ACT_W-1:0] random_act();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7fff;
         default: return ACT_W'($urandom);
      endcase
   endfunction

   function automatic matvec_op_type random_op(int span_cols, int span_rows);
      int pick;
      int area;
      int idx;
      pick = $urandom_range(99);
      area = span_cols * span_rows;
      if (pick < 40) begin
         if (area > 0 && $urandom_range(3) != 0)
            idx = $urandom_range(area - 1);
         else
            idx = $urandom_range((1 << FLAT_W) - 1);
         return weight_op(idx, CODE_W'($urandom_range(3)), 1'($urandom));
      end
      if (span_cols > 0 && $urandom_range(3) != 0)
         idx = $urandom_range(span_cols - 1);
      else
         idx = $urandom_range(MAX_INPUTS - 1);
      return act_op(idx, random_act(), pick >= 88);
   endfunction

   task automatic send_op(input matvec_op_type op);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start             <= 1'b1;
      req_kind          <= op.kind;
      req_weight_index  <= op.windex;
      req_weight_value  <= op.wvalue;
      req_act_index     <= op.aindex;
      req_act_value     <= op.avalue;
      req_start_compute <= op.go;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic wait_quiet();
      start <= 1'b0;
      @(posedge clock);
      while (model.pending_rows.size() != 0 || busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(4 * int'(idx));
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      model.set_register(idx, data);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      model.check_register(idx, prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input int cols, input int rows, input logic [SCALE_W-1:0] scale);
      write_csr(CSR_INPUT_LENGTH, CSR_W'(cols));
      write_csr(CSR_OUTPUT_LENGTH, CSR_W'(rows));
      write_csr(CSR_SCALE_FACTOR, CSR_W'(scale));
   endtask

   task automatic run_phase(input int cols, input int rows, input logic [SCALE_W-1:0] scale,
                            input int n_items, input int gap);
      int span_cols;
      int span_rows;
      span_cols = (cols > MAX_INPUTS) ? MAX_INPUTS : cols;
      span_rows = (rows > MAX_OUTPUTS) ? MAX_OUTPUTS : rows;
      wait_quiet();
      configure(cols, rows, scale);
      gap_pct = gap;
      for (int n = 0; n < span_rows * span_cols; n++)
         send_op(weight_op(n, CODE_W'($urandom_range(3)), 1'b0));
      if (span_cols == 0)
         send_op(act_op($urandom_range(MAX_INPUTS - 1), random_act(), 1'b1));
      for (int j = 0; j < span_cols; j++)
         send_op(act_op(j, random_act(), j == span_cols - 1));
      repeat (n_items) send_op(random_op(span_cols, span_rows));
   endtask

   initial begin
      model = new();
      gap_pct = 0;
      reset             <= 1'b1;
      start             <= 1'b0;
      req_kind          <= KIND_WEIGHT;
      req_weight_index  <= '0;
      req_weight_value  <= W_ZERO;
      req_act_index     <= '0;
      req_act_value     <= '0;
      req_start_compute <= 1'b0;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      wait_quiet();
      configure(4, 2, SCALE_RESET);
      send_op(weight_op((1 << FLAT_W) - 1, W_PLUS, 1'b0));
      send_op(weight_op((1 << FLAT_W) - 2, W_MINUS2, 1'b1));
      send_op(weight_op(0, W_PLUS, 1'b0));
      send_op(weight_op(1, W_MINUS, 1'b0));
      send_op(weight_op(2, W_MINUS2, 1'b1));
      send_op(weight_op(3, W_ZERO, 1'b0));
      send_op(weight_op(4, W_MINUS, 1'b0));
      send_op(weight_op(5, W_PLUS, 1'b0));
      send_op(weight_op(6, W_PLUS, 1'b0));
      send_op(weight_op(7, W_MINUS2, 1'b0));
      send_op(act_op(MAX_INPUTS - 1, 16'h8000, 1'b0));
      send_op(act_op(0, 16'h7fff, 1'b0));
      send_op(act_op(1, 16'h8000, 1'b0));
      send_op(act_op(2, 16'hffff, 1'b0));
      send_op(act_op(3, 16'h0001, 1'b1));
      send_op(act_op(3, 16'h8000, 1'b1));
      send_op(weight_op(3, W_PLUS, 1'b0));
      send_op(act_op(2, 16'h7fff, 1'b1));

      run_phase(1, 20, 16'h7fff, 6, 0);
      run_phase(0, 127, SCALE_RESET, 5, 62);
      run_phase(5, 0, 16'd1000, 4, 15);
      run_phase(4, 3, 16'h8000, 8, 62);
      run_phase(3, 5, 16'hf000, 8, 15);
      for (int p = 0; p < 3; p++)
         run_phase($urandom_range(6, 1), $urandom_range(4, 1), SCALE_W'($urandom), 8,
                   (p % 3 == 0) ? 0 : (p % 3 == 1) ? 62 : 15);

      wait_quiet();
      if (model.errors == 0 && model.pending_rows.size() == 0)
         $display("PASS ternary_matrix_vector_multiply");
      else
         $display("FAIL ternary_matrix_vector_multiply");
      $finish;
   end

endmodule

### filelist.f
+incdir+hdl
hdl/tmvm_pkg.sv
hdl/tmvm_row_scale.sv
hdl/ternary_matrix_vector_multiply.sv
hdl/tmvm_checker.sv
sim/tb_ternary_matrix_vector_multiply.sv
